>>> rtl/vwce_pkg.sv
package vwce_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam logic [15:0] CHUNK_SAMPLES  = 16'hFFFF;
    localparam logic [1:0]  CHUNK_LAST_IDX = 2'd2;
    localparam logic [31:0] TICK_INTERVAL_RST = 32'd48168960;

    // request kinds
    localparam logic [1:0] FUNC_DELAY_SAMPLES = 2'd0;
    localparam logic [1:0] FUNC_DELAY_TICKS   = 2'd1;
    localparam logic [1:0] FUNC_CMD_BYTE      = 2'd2;
    localparam logic [1:0] FUNC_END           = 2'd3;

    // wait command bytes
    localparam logic [7:0] VGM_WAIT_N     = 8'h61;
    localparam logic [7:0] VGM_WAIT_60HZ  = 8'h62;
    localparam logic [7:0] VGM_WAIT_50HZ  = 8'h63;
    localparam logic [7:0] VGM_END        = 8'h66;
    localparam logic [7:0] VGM_SHORT_BASE = 8'h6F;
    localparam logic [7:0] VGM_WAIT_16    = 8'h7F;
    localparam logic [7:0] VGM_PAIR_BASE  = 8'h5F;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_MULT   = 7'b0000010,
        ST_ADD    = 7'b0000100,
        ST_CHECK  = 7'b0001000,
        ST_DECIDE = 7'b0010000,
        ST_CHUNK  = 7'b0100000,
        ST_REST   = 7'b1000000
    } state_t;

    typedef enum logic [1:0] {
        SEL_CHUNK = 2'd0,
        SEL_REST  = 2'd1,
        SEL_CMD   = 2'd2
    } sel_t;

    typedef struct packed {
        logic       load_in;
        logic       load_prod;
        logic       add_time;
        logic       load_pend;
        logic       emit;
        sel_t       sel;
        logic [1:0] idx;
        logic       last;
        logic       commit_chunk;
        logic       commit_rest;
    } dp_cmd_t;

    typedef struct packed {
        logic       chunk_avail;
        logic       more_chunk;
        logic       rest_nz;
        logic       out_free;
        logic       flush;
        logic [1:0] wait_cnt;
    } dp_status_t;

    // number of bytes that encode a wait of t samples (t nonzero)
    function automatic logic [1:0] wait_len(input logic [15:0] t);
        logic [1:0] n;
        case (t)
            16'd1764, 16'd1470: n = 2'd2;
            16'd882, 16'd735:   n = 2'd1;
            default: begin
                if (t <= 16'd16) begin
                    n = 2'd1;
                end else if (t <= 16'd32) begin
                    n = 2'd2;
                end else begin
                    n = 2'd3;
                end
            end
        endcase
        return n;
    endfunction

    // byte idx of the wait encoding of t samples
    function automatic logic [7:0] wait_byte(input logic [15:0] t, input logic [1:0] idx);
        logic [7:0] b;
        case (t)
            16'd1764, 16'd882:  b = VGM_WAIT_50HZ;
            16'd1470, 16'd735:  b = VGM_WAIT_60HZ;
            default: begin
                if (t <= 16'd16) begin
                    b = VGM_SHORT_BASE + t[7:0];
                end else if (t <= 16'd32) begin
                    b = (idx == 2'd0) ? VGM_WAIT_16 : VGM_PAIR_BASE + t[7:0];
                end else begin
                    case (idx)
                        2'd0:    b = VGM_WAIT_N;
                        2'd1:    b = t[7:0];
                        default: b = t[15:8];
                    endcase
                end
            end
        endcase
        return b;
    endfunction

endpackage

>>> rtl/vgm_wait_command_encoder.sv
// Channel  | Dir | Handshake          | Payload
// s_*      | in  | s_tvalid/s_tready  | s_tuser[1:0] func, s_tdata amount|cmd_byte
// m_*      | out | m_tvalid/m_tready  | m_tdata out_byte, m_tlast last, m_tuser overflow
// cfg_*    | in  | cfg_wen            | cfg_wdata tick_interval
//
// One request at a time. Sample delay: ADD, CHECK, DECIDE; tick delay: MULT first (the
// 4x32 multiply); then 3 bytes and a DECIDE re-check per full 65535-sample chunk.
// Command/end: CHECK, DECIDE and any chunks, then the remainder bytes (0 to 3) and the command or end byte.
// Output register lets the sequencer run ahead by one byte; a stalled m_tready
// holds the sequencer. Synchronous active-low reset, no clearing pass.
module vgm_wait_command_encoder #(
    parameter int FRAC_BITS = vwce_pkg::FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wen,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] amount, [23:16] cmd_byte
    input  logic [1:0]  s_tuser,   // [1:0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast,
    output logic [0:0]  m_tuser    // [0] overflow
);
    import vwce_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t st;

    vwce_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_func   (s_tuser),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    vwce_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wen    (cfg_wen),
        .cfg_wdata  (cfg_wdata),
        .s_func     (s_tuser),
        .s_amount   (s_tdata[15:0]),
        .s_cmd_byte (s_tdata[23:16]),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_out_byte (m_tdata),
        .m_last     (m_tlast),
        .m_overflow (m_tuser[0]),
        .cmd        (cmd),
        .st         (st)
    );

endmodule

>>> rtl/vwce_ctrl.sv
module vwce_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic [1:0]           s_func,
    output logic                 s_tready,
    input  vwce_pkg::dp_status_t st,
    output vwce_pkg::dp_cmd_t    cmd
);
    import vwce_pkg::*;

    state_t     state_reg, state_next;
    logic [1:0] idx_reg, idx_next;
    logic       accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= 2'd0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        cmd.sel    = SEL_CHUNK;
        cmd.idx    = idx_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.load_in = 1'b1;
                    idx_next    = 2'd0;
                    case (s_func)
                        FUNC_DELAY_SAMPLES: state_next = ST_ADD;
                        FUNC_DELAY_TICKS:   state_next = ST_MULT;
                        default:            state_next = ST_CHECK;
                    endcase
                end
            end
            ST_MULT: begin
                cmd.load_prod = 1'b1;
                state_next    = ST_ADD;
            end
            ST_ADD: begin
                cmd.add_time = 1'b1;
                state_next   = ST_CHECK;
            end
            ST_CHECK: begin
                cmd.load_pend = 1'b1;
                state_next    = ST_DECIDE;
            end
            ST_DECIDE: begin
                idx_next = 2'd0;
                if (st.chunk_avail) begin
                    state_next = ST_CHUNK;
                end else if (st.flush) begin
                    state_next = ST_REST;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_CHUNK: begin
                cmd.sel  = SEL_CHUNK;
                cmd.emit = st.out_free;
                cmd.last = !st.flush && (idx_reg == CHUNK_LAST_IDX) && !st.more_chunk;
                if (st.out_free) begin
                    if (idx_reg == CHUNK_LAST_IDX) begin
                        cmd.commit_chunk = 1'b1;
                        idx_next         = 2'd0;
                        state_next       = ST_DECIDE;
                    end else begin
                        idx_next = idx_reg + 2'd1;
                    end
                end
            end
            ST_REST: begin
                // remainder bytes (if any), then the command or end byte
                if (!st.rest_nz) begin
                    cmd.sel  = SEL_CMD;
                    cmd.last = 1'b1;
                    cmd.emit = st.out_free;
                    if (st.out_free) begin
                        state_next = ST_IDLE;
                    end
                end else begin
                    cmd.sel  = SEL_REST;
                    cmd.emit = st.out_free;
                    if (st.out_free) begin
                        if (idx_reg == st.wait_cnt - 2'd1) begin
                            cmd.commit_rest = 1'b1;
                            idx_next        = 2'd0;
                        end else begin
                            idx_next = idx_reg + 2'd1;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/vwce_dp.sv
module vwce_dp #(
    parameter int FRAC_BITS = vwce_pkg::FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wen,
    input  logic [31:0]          cfg_wdata,
    input  logic [1:0]           s_func,
    input  logic [15:0]          s_amount,
    input  logic [7:0]           s_cmd_byte,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_out_byte,
    output logic                 m_last,
    output logic                 m_overflow,
    input  vwce_pkg::dp_cmd_t    cmd,
    output vwce_pkg::dp_status_t st
);
    import vwce_pkg::*;

    localparam int TW = 33 + FRAC_BITS;
    localparam int UP = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int DN = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

    localparam logic [TW-1:0] TIME_LIMIT = TW'(33'h0_FFFF_FFFF) << FRAC_BITS;
    localparam logic [TW-1:0] TIME_SAT   = TW'(1) << (32 + FRAC_BITS);

    logic [31:0]   tick_reg;
    logic [1:0]    func_reg;
    logic [15:0]   amount_reg;
    logic [7:0]    cmd_byte_reg;
    logic [35:0]   prod_reg;
    logic [TW-1:0] time_reg;
    logic [32:0]   written_reg;
    logic [32:0]   pend_reg;
    logic          ovf_reg;

    logic          mv_reg;
    logic [7:0]    mbyte_reg;
    logic          mlast_reg;
    logic          movf_reg;

    logic [3:0]    ticks;
    logic [TW-1:0] delta;
    logic [TW:0]   sum;
    logic [15:0]   wait_t;
    logic [7:0]    emit_byte;

    assign ticks = (amount_reg > 16'd15) ? 4'd15 : amount_reg[3:0];
    assign delta = (func_reg == FUNC_DELAY_SAMPLES) ? (TW'(amount_reg) << FRAC_BITS)
                                                    : ((TW'(prod_reg) << UP) >> DN);
    assign sum   = {1'b0, time_reg} + {1'b0, delta};

    assign wait_t = (cmd.sel == SEL_REST) ? pend_reg[15:0] : CHUNK_SAMPLES;

    always_comb begin
        case (cmd.sel)
            SEL_CMD:  emit_byte = (func_reg == FUNC_END) ? VGM_END : cmd_byte_reg;
            default:  emit_byte = wait_byte(wait_t, cmd.idx);
        endcase
    end

    assign st.chunk_avail = pend_reg >= 33'(CHUNK_SAMPLES);
    assign st.more_chunk  = pend_reg >= (33'(CHUNK_SAMPLES) << 1);
    assign st.rest_nz     = pend_reg != 33'd0;
    assign st.out_free    = !mv_reg || m_tready;
    assign st.flush       = func_reg[1];
    assign st.wait_cnt    = wait_len(pend_reg[15:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg    <= TICK_INTERVAL_RST;
            time_reg    <= '0;
            written_reg <= '0;
            ovf_reg     <= 1'b0;
        end else begin
            if (cfg_wen) begin
                tick_reg <= cfg_wdata;
            end
            if (cmd.add_time) begin
                if (sum > {1'b0, TIME_LIMIT}) begin
                    time_reg <= TIME_SAT;
                    ovf_reg  <= 1'b1;
                end else begin
                    time_reg <= sum[TW-1:0];
                end
            end
            if (cmd.commit_chunk) begin
                written_reg <= written_reg + 33'(CHUNK_SAMPLES);
            end else if (cmd.commit_rest) begin
                written_reg <= written_reg + pend_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            func_reg     <= s_func;
            amount_reg   <= s_amount;
            cmd_byte_reg <= s_cmd_byte;
        end
        if (cmd.load_prod) begin
            prod_reg <= 36'(ticks) * 36'(tick_reg);
        end
        if (cmd.load_pend) begin
            pend_reg <= time_reg[TW-1:FRAC_BITS] - written_reg;
        end else if (cmd.commit_chunk) begin
            pend_reg <= pend_reg - 33'(CHUNK_SAMPLES);
        end else if (cmd.commit_rest) begin
            pend_reg <= '0;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= 1'b0;
        end else if (cmd.emit) begin
            mv_reg <= 1'b1;
        end else if (m_tready) begin
            mv_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            mbyte_reg <= emit_byte;
            mlast_reg <= cmd.last;
            movf_reg  <= ovf_reg;
        end
    end

    assign m_tvalid   = mv_reg;
    assign m_out_byte = mbyte_reg;
    assign m_last     = mlast_reg;
    assign m_overflow = movf_reg;

endmodule
